>>> rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// hsv_pkg: shared types for the RGB to HSV converter
// Sector codes for the hue formula and the per-pixel flags that travel
// alongside the divider pipelines.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // Channel that holds the maximum; blue wins ties over green, green over red
    typedef enum logic [1:0] {
        SECTOR_RED   = 2'd0,
        SECTOR_GREEN = 2'd1,
        SECTOR_BLUE  = 2'd2
    } sector_t;

    // Special cases known before the divides finish
    typedef struct packed {
        logic zero_chroma;
        logic zero_value;
    } front_flags_t;

endpackage

>>> rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// hsv_front: max/min, chroma and sector numerator
// Two register stages that turn one RGB pixel into the operands of the
// saturation and hue divides, plus the gray and black pixel flags.
// ----------------------------------------------------------------------------
module hsv_front #(
    parameter int CHANNEL_BITS = 8
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      advance,
    input  logic                      in_valid,
    input  logic [CHANNEL_BITS-1:0]   red_level,
    input  logic [CHANNEL_BITS-1:0]   green_level,
    input  logic [CHANNEL_BITS-1:0]   blue_level,
    output logic                      out_valid,
    output hsv_pkg::front_flags_t     out_flags,
    output logic [CHANNEL_BITS-1:0]   out_value,
    output logic [CHANNEL_BITS+2:0]   out_hue_num,
    output logic [CHANNEL_BITS+2:0]   out_hue_den,
    output logic [2*CHANNEL_BITS-1:0] out_sat_num
);
    import hsv_pkg::*;

    localparam int CW = CHANNEL_BITS;

    // stage 1
    sector_t        sector_next;
    logic [CW-1:0]  hi_next;
    logic [CW-1:0]  lo_next;
    logic [CW-1:0]  chroma_next;
    logic [CW:0]    diff_next;

    logic           valid1_reg;
    sector_t        sector1_reg;
    logic [CW-1:0]  hi1_reg;
    logic [CW-1:0]  chroma1_reg;
    logic [CW:0]    diff1_reg;

    // stage 2
    logic [CW+2:0]      chroma_ext;
    logic [CW+2:0]      offset;
    logic [CW+2:0]      den_next;
    logic [CW+3:0]      sum;
    logic [CW+3:0]      wrapped;
    logic [CW+2:0]      num_next;
    logic [2*CW-1:0]    sat_num_next;
    front_flags_t       flags_next;

    logic               valid2_reg;
    front_flags_t       flags2_reg;
    logic [CW-1:0]      hi2_reg;
    logic [CW+2:0]      num2_reg;
    logic [CW+2:0]      den2_reg;
    logic [2*CW-1:0]    sat_num2_reg;

    always_comb begin
        priority if (blue_level >= red_level && blue_level >= green_level) begin
            sector_next = SECTOR_BLUE;
            hi_next     = blue_level;
            diff_next   = {1'b0, red_level} - {1'b0, green_level};
        end else if (green_level >= red_level) begin
            sector_next = SECTOR_GREEN;
            hi_next     = green_level;
            diff_next   = {1'b0, blue_level} - {1'b0, red_level};
        end else begin
            sector_next = SECTOR_RED;
            hi_next     = red_level;
            diff_next   = {1'b0, green_level} - {1'b0, blue_level};
        end
        lo_next = red_level;
        if (green_level < lo_next) begin
            lo_next = green_level;
        end
        if (blue_level < lo_next) begin
            lo_next = blue_level;
        end
        chroma_next = hi_next - lo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (advance) begin
            valid1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            sector1_reg <= sector_next;
            hi1_reg     <= hi_next;
            chroma1_reg <= chroma_next;
            diff1_reg   <= diff_next;
        end
    end

    always_comb begin
        chroma_ext = {3'b000, chroma1_reg};
        unique case (sector1_reg)
            SECTOR_GREEN: offset = chroma_ext << 1;
            SECTOR_BLUE:  offset = chroma_ext << 2;
            default:      offset = '0;
        endcase
        den_next = (chroma_ext << 2) + (chroma_ext << 1);
        sum      = {1'b0, offset} + {{3{diff1_reg[CW]}}, diff1_reg};
        // wrap a negative red-sector numerator into [0, 6*chroma)
        wrapped  = sum[CW+3] ? (sum + {1'b0, den_next}) : sum;
        num_next = wrapped[CW+2:0];
        sat_num_next = {chroma1_reg, {CW{1'b0}}} - {{CW{1'b0}}, chroma1_reg};
        flags_next.zero_chroma = (chroma1_reg == '0);
        flags_next.zero_value  = (hi1_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid2_reg <= 1'b0;
        end else if (advance) begin
            valid2_reg <= valid1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            flags2_reg   <= flags_next;
            hi2_reg      <= hi1_reg;
            num2_reg     <= num_next;
            den2_reg     <= den_next;
            sat_num2_reg <= sat_num_next;
        end
    end

    assign out_valid   = valid2_reg;
    assign out_flags   = flags2_reg;
    assign out_value   = hi2_reg;
    assign out_hue_num = num2_reg;
    assign out_hue_den = den2_reg;
    assign out_sat_num = sat_num2_reg;

endmodule

>>> rtl/hsv_div_pipe.sv
// ----------------------------------------------------------------------------
// hsv_div_pipe: pipelined restoring divider
// One quotient bit per register stage. The dividend is split into a high
// part, which must be below the divisor, and low bits shifted in one per
// step. Stages past the quotient width pass the result through.
// ----------------------------------------------------------------------------
module hsv_div_pipe #(
    parameter int DEN_BITS = 8,
    parameter int QUO_BITS = 8,
    parameter int STAGES   = 8
) (
    input  logic                aclk,
    input  logic                advance,
    input  logic [DEN_BITS-1:0] rem_init,
    input  logic [QUO_BITS-1:0] low_bits,
    input  logic [DEN_BITS-1:0] den,
    output logic [QUO_BITS-1:0] quotient
);
    import hsv_pkg::*;

    logic [DEN_BITS-1:0] rem_reg  [STAGES];
    logic [QUO_BITS-1:0] quo_reg  [STAGES];
    logic [DEN_BITS-1:0] den_reg  [STAGES];
    logic [DEN_BITS-1:0] rem_next [STAGES];
    logic [QUO_BITS-1:0] quo_next [STAGES];
    logic [DEN_BITS-1:0] den_next [STAGES];

    always_comb begin
        logic [DEN_BITS-1:0] rem_in;
        logic [QUO_BITS-1:0] quo_in;
        logic [DEN_BITS-1:0] den_in;
        logic [DEN_BITS:0]   trial;
        logic [DEN_BITS:0]   diff;
        logic                take;
        for (int s = 0; s < STAGES; s++) begin
            if (s == 0) begin
                rem_in = rem_init;
                quo_in = low_bits;
                den_in = den;
            end else begin
                rem_in = rem_reg[s-1];
                quo_in = quo_reg[s-1];
                den_in = den_reg[s-1];
            end
            trial = {rem_in, quo_in[QUO_BITS-1]};
            diff  = trial - {1'b0, den_in};
            take  = (trial >= {1'b0, den_in});
            if (s < QUO_BITS) begin
                rem_next[s] = take ? diff[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
                quo_next[s] = {quo_in[QUO_BITS-2:0], take};
            end else begin
                rem_next[s] = rem_in;
                quo_next[s] = quo_in;
            end
            den_next[s] = den_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            for (int s = 0; s < STAGES; s++) begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
                den_reg[s] <= den_next[s];
            end
        end
    end

    assign quotient = quo_reg[STAGES-1];

endmodule

>>> rtl/rgb_to_hsv_pixel_converter_unit.sv
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_converter_unit: streaming RGB to HSV conversion
// Pipeline: two front stages, one divider stage per bit of the wider quotient,
//   one output register.
// Throughput: one pixel per cycle while m_ready does not stall; the wider quotient
//   sets the divider depth. A stall on m_ready holds every stage in place.
// Reset: synchronous active-low aresetn clears all valid bits; data is kept.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_converter_unit #(
    parameter int CHANNEL_BITS = 8,
    parameter int HUE_BITS     = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_red_level,
    input  logic [CHANNEL_BITS-1:0] s_green_level,
    input  logic [CHANNEL_BITS-1:0] s_blue_level,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [HUE_BITS-1:0]     m_hue_turn,
    output logic [CHANNEL_BITS-1:0] m_saturation_level,
    output logic [CHANNEL_BITS-1:0] m_value_level
);
    import hsv_pkg::*;

    localparam int CW         = CHANNEL_BITS;
    localparam int DIV_STAGES = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

    logic               advance;
    logic               front_valid;
    front_flags_t       front_flags;
    logic [CW-1:0]      front_value;
    logic [CW+2:0]      hue_num;
    logic [CW+2:0]      hue_den;
    logic [2*CW-1:0]    sat_num;
    logic [HUE_BITS-1:0] hue_quo;
    logic [CW-1:0]      sat_quo;

    logic [DIV_STAGES-1:0] valid_line_reg;
    front_flags_t          flags_line_reg [DIV_STAGES];
    logic [CW-1:0]         value_line_reg [DIV_STAGES];

    logic                  m_valid_reg;
    logic [HUE_BITS-1:0]   hue_reg;
    logic [CW-1:0]         sat_reg;
    logic [CW-1:0]         value_reg;

    // whole pipeline moves together; the output register frees a slot as it drains
    assign advance = !m_valid_reg || m_ready;
    assign s_ready = advance;

    hsv_front #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .in_valid    (s_valid),
        .red_level   (s_red_level),
        .green_level (s_green_level),
        .blue_level  (s_blue_level),
        .out_valid   (front_valid),
        .out_flags   (front_flags),
        .out_value   (front_value),
        .out_hue_num (hue_num),
        .out_hue_den (hue_den),
        .out_sat_num (sat_num)
    );

    hsv_div_pipe #(
        .DEN_BITS (CW + 3),
        .QUO_BITS (HUE_BITS),
        .STAGES   (DIV_STAGES)
    ) u_hue_div (
        .aclk     (aclk),
        .advance  (advance),
        .rem_init (hue_num),
        .low_bits ({HUE_BITS{1'b0}}),
        .den      (hue_den),
        .quotient (hue_quo)
    );

    hsv_div_pipe #(
        .DEN_BITS (CW),
        .QUO_BITS (CW),
        .STAGES   (DIV_STAGES)
    ) u_sat_div (
        .aclk     (aclk),
        .advance  (advance),
        .rem_init (sat_num[2*CW-1:CW]),
        .low_bits (sat_num[CW-1:0]),
        .den      (front_value),
        .quotient (sat_quo)
    );

    // carry valid, flags and value level alongside the dividers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_line_reg <= '0;
        end else if (advance) begin
            valid_line_reg <= {valid_line_reg[DIV_STAGES-2:0], front_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            flags_line_reg[0] <= front_flags;
            value_line_reg[0] <= front_value;
            for (int s = 1; s < DIV_STAGES; s++) begin
                flags_line_reg[s] <= flags_line_reg[s-1];
                value_line_reg[s] <= value_line_reg[s-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= valid_line_reg[DIV_STAGES-1];
        end
    end

    // drop the divide results for gray and black pixels
    always_ff @(posedge aclk) begin
        if (advance) begin
            hue_reg   <= flags_line_reg[DIV_STAGES-1].zero_chroma ? '0 : hue_quo;
            sat_reg   <= flags_line_reg[DIV_STAGES-1].zero_value ? '0 : sat_quo;
            value_reg <= value_line_reg[DIV_STAGES-1];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_hue_turn         = hue_reg;
    assign m_saturation_level = sat_reg;
    assign m_value_level      = value_reg;

    a_black_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_value_level == '0 |-> m_saturation_level == '0 && m_hue_turn == '0)
        else $error("black pixel with nonzero saturation or hue");

    a_gray_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturation_level == '0 |-> m_hue_turn == '0)
        else $error("zero saturation with nonzero hue");

    a_stall_holds_line: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> $stable(valid_line_reg) && $stable(front_valid))
        else $error("pipeline moved during a stall");

endmodule
